// File: hdl/lfpd_pkg.sv
// Shared types, constants and the sensor error table for the line-follow PID drive.
// No dependencies; every other file in hdl imports this package.
`timescale 1ns / 1ps
package lfpd_pkg;

   localparam int INTEGRAL_BITS = 24;
   localparam int DUTY_LIMIT    = 9999;

   localparam int SENSOR_W = 8;
   localparam int GAIN_W   = 12;
   localparam int SPEED_W  = 14;
   localparam int ERROR_W  = 4;
   localparam int DELTA_W  = ERROR_W + 1;
   localparam int DUTY_W   = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SPEED_W;

   // product and sum widths; the integral product dominates
   localparam int PROD_P_W = GAIN_W + 1 + ERROR_W;
   localparam int PROD_I_W = GAIN_W + 1 + INTEGRAL_BITS;
   localparam int PROD_D_W = GAIN_W + 1 + DELTA_W;
   localparam int PID_W    = PROD_I_W + 2;

   localparam int DUTY_BITS = $clog2(DUTY_LIMIT + 1);
   localparam int CMD_W     = DUTY_BITS + 1;
   localparam int MAG_W     = (DUTY_BITS > DUTY_W) ? DUTY_BITS : DUTY_W;

   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   localparam logic [SENSOR_W-1:0] ALL_WHITE = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P     = 2'd0,
      REG_GAIN_I     = 2'd1,
      REG_GAIN_D     = 2'd2,
      REG_BASE_SPEED = 2'd3
   } lfpd_reg_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [SPEED_W-1:0] base_speed;
   } lfpd_cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic signed [ERROR_W-1:0]       error;
      logic signed [DELTA_W-1:0]       delta;
      logic signed [INTEGRAL_BITS-1:0] sum;
      logic                            all_white;
   } lfpd_cmd_type;

   typedef struct packed {
      logic                      left_forward;
      logic [DUTY_W-1:0]         left_duty;
      logic                      right_forward;
      logic [DUTY_W-1:0]         right_duty;
      logic signed [ERROR_W-1:0] error_halves;
      logic                      all_white;
   } lfpd_rsp_type;

   typedef struct packed {
      logic [OUTQ_CNT_W-1:0] inflight;
   } lfpd_back_status_type;

   // position error in halves, L4..R4 from bit 7 down; unlisted patterns keep the old error
   function automatic logic signed [ERROR_W-1:0] lfpd_map_error(
      input logic [SENSOR_W-1:0]        s,
      input logic signed [ERROR_W-1:0]  keep
   );
      logic signed [ERROR_W-1:0] e;
      case (s)
         8'h7F, 8'h3F, 8'hBF, 8'h9F: e = 4'sd4;
         8'hDF:                      e = 4'sd2;
         8'hCF, 8'hEF:               e = 4'sd1;
         8'hE7:                      e = 4'sd0;
         8'hF7, 8'hF3:               e = -4'sd1;
         8'hFB:                      e = -4'sd2;
         8'hF9, 8'hFD, 8'hFC, 8'hFE: e = -4'sd4;
         8'h00:                      e = 4'sd0;
         default:                    e = keep;
      endcase
      return e;
   endfunction

endpackage

// File: hdl/lfpd_front.sv
// Front end: takes sensor samples, maps them to an error and keeps the integral.
// Depends on lfpd_pkg.
`timescale 1ns / 1ps
module lfpd_front
   import lfpd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [SENSOR_W-1:0] req_sensor_bits,
   input  logic                cmdq_full,
   output logic                cmd_push,
   output lfpd_cmd_type        cmd
);

   logic signed [ERROR_W-1:0]       held_error_ff, held_error_in;
   logic signed [INTEGRAL_BITS-1:0] error_sum_ff, error_sum_in;
   logic signed [ERROR_W-1:0]       error_now;
   logic signed [INTEGRAL_BITS:0]   sum_wide;
   logic signed [INTEGRAL_BITS-1:0] sum_sat;

   always_comb begin
      error_now = lfpd_map_error(req_sensor_bits, held_error_ff);
      sum_wide  = {error_sum_ff[INTEGRAL_BITS-1], error_sum_ff}
                + {{(INTEGRAL_BITS + 1 - ERROR_W){error_now[ERROR_W-1]}}, error_now};
      // saturate when the top two bits disagree
      if (sum_wide[INTEGRAL_BITS] != sum_wide[INTEGRAL_BITS-1]) begin
         sum_sat = sum_wide[INTEGRAL_BITS] ? {1'b1, {(INTEGRAL_BITS-1){1'b0}}}
                                           : {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[INTEGRAL_BITS-1:0];
      end

      cmd_push      = req_push && !cmdq_full;
      cmd.error     = error_now;
      cmd.delta     = {error_now[ERROR_W-1], error_now}
                    - {held_error_ff[ERROR_W-1], held_error_ff};
      cmd.sum       = sum_sat;
      cmd.all_white = (req_sensor_bits == ALL_WHITE);

      held_error_in = cmd_push ? error_now : held_error_ff;
      error_sum_in  = cmd_push ? sum_sat : error_sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_error_ff <= '0;
         error_sum_ff  <= '0;
      end else begin
         held_error_ff <= held_error_in;
         error_sum_ff  <= error_sum_in;
      end
   end

endmodule

// File: hdl/lfpd_cmd_queue.sv
// Short queue of classified items between the front and the back.
// Depends on lfpd_pkg.
`timescale 1ns / 1ps
module lfpd_cmd_queue
   import lfpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  lfpd_cmd_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         valid,
   output lfpd_cmd_type head
);

   lfpd_cmd_type            entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   always_comb begin
      full    = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
      valid   = (count_ff != '0);
      head    = entry_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop  = pop && valid;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hdl/lfpd_back.sv
// Back end: PID products, halving, wheel clamps and the result queue.
// Depends on lfpd_pkg.
`timescale 1ns / 1ps
module lfpd_back
   import lfpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  lfpd_cfg_type         cfg,
   input  logic                 cmd_valid,
   input  lfpd_cmd_type         cmd,
   output logic                 cmd_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output lfpd_rsp_type         rsp,
   output lfpd_back_status_type status
);

   localparam logic signed [PID_W:0] LIMIT_POS = (PID_W + 1)'(DUTY_LIMIT);
   localparam logic signed [PID_W:0] LIMIT_NEG = -LIMIT_POS;

   // stage 1: products
   logic                         s1_valid_ff, s1_valid_in;
   logic signed [PROD_P_W-1:0]   s1_prod_p_ff;
   logic signed [PROD_I_W-1:0]   s1_prod_i_ff;
   logic signed [PROD_D_W-1:0]   s1_prod_d_ff;
   logic signed [ERROR_W-1:0]    s1_error_ff;
   logic                         s1_white_ff;

   // stage 2: halved PID value
   logic                         s2_valid_ff, s2_valid_in;
   logic signed [PID_W-1:0]      s2_pid_ff;
   logic signed [ERROR_W-1:0]    s2_error_ff;
   logic                         s2_white_ff;

   logic signed [PID_W-1:0]      pid_sum;
   logic signed [PID_W-1:0]      pid_half;

   logic signed [PID_W:0]        base_ext, pid_ext, left_raw, right_raw, left_clip, right_clip;
   logic signed [CMD_W-1:0]      left_cmd, right_cmd, left_abs, right_abs;
   logic [MAG_W-1:0]             left_mag, right_mag;
   lfpd_rsp_type                 result;

   // result queue
   lfpd_rsp_type                 outq_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_CNT_W-1:0]        count_ff, count_in;
   logic [OUTQ_CNT_W-1:0]        inflight;
   logic                         do_pop;

   always_comb begin
      // hold items back unless the result queue can take everything in flight
      inflight = OUTQ_CNT_W'(s1_valid_ff) + OUTQ_CNT_W'(s2_valid_ff) + count_ff;
      cmd_pop  = cmd_valid && (inflight < OUTQ_CNT_W'(OUTQ_DEPTH));
      status.inflight = inflight;
      s1_valid_in = cmd_pop;
      s2_valid_in = s1_valid_ff;

      pid_sum  = PID_W'(s1_prod_p_ff) + PID_W'(s1_prod_i_ff) + PID_W'(s1_prod_d_ff);
      // halve toward zero: bias negative sums by one before the shift
      pid_half = (pid_sum + $signed(PID_W'(pid_sum[PID_W-1]))) >>> 1;

      base_ext  = $signed({{(PID_W + 1 - SPEED_W){1'b0}}, cfg.base_speed});
      pid_ext   = {s2_pid_ff[PID_W-1], s2_pid_ff};
      left_raw  = base_ext - pid_ext;
      right_raw = base_ext + pid_ext;

      if (left_raw > LIMIT_POS) begin
         left_clip = LIMIT_POS;
      end else if (left_raw < LIMIT_NEG) begin
         left_clip = LIMIT_NEG;
      end else begin
         left_clip = left_raw;
      end
      if (right_raw > LIMIT_POS) begin
         right_clip = LIMIT_POS;
      end else if (right_raw < LIMIT_NEG) begin
         right_clip = LIMIT_NEG;
      end else begin
         right_clip = right_raw;
      end

      left_cmd  = left_clip[CMD_W-1:0];
      right_cmd = right_clip[CMD_W-1:0];
      left_abs  = left_cmd[CMD_W-1] ? -left_cmd : left_cmd;
      right_abs = right_cmd[CMD_W-1] ? -right_cmd : right_cmd;
      left_mag  = MAG_W'(left_abs[DUTY_BITS-1:0]);
      right_mag = MAG_W'(right_abs[DUTY_BITS-1:0]);

      // left command is negated: forward when the clamped left speed is negative
      result.left_forward  = left_cmd[CMD_W-1];
      result.left_duty     = left_mag[DUTY_W-1:0];
      result.right_forward = !right_cmd[CMD_W-1] && (right_cmd != '0);
      result.right_duty    = right_mag[DUTY_W-1:0];
      result.error_halves  = s2_error_ff;
      result.all_white     = s2_white_ff;

      rsp_empty = (count_ff == '0);
      rsp       = outq_ff[rd_ptr_ff];
      do_pop    = rsp_pop && !rsp_empty;

      wr_ptr_in = s2_valid_ff ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (s2_valid_ff && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !s2_valid_ff) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         s1_prod_p_ff <= $signed({1'b0, cfg.gain_p}) * cmd.error;
         s1_prod_i_ff <= $signed({1'b0, cfg.gain_i}) * cmd.sum;
         s1_prod_d_ff <= $signed({1'b0, cfg.gain_d}) * cmd.delta;
         s1_error_ff  <= cmd.error;
         s1_white_ff  <= cmd.all_white;
      end
      if (s1_valid_ff) begin
         s2_pid_ff   <= pid_half;
         s2_error_ff <= s1_error_ff;
         s2_white_ff <= s1_white_ff;
      end
      if (s2_valid_ff) begin
         outq_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

// File: hdl/line_follow_pid_drive_core.sv
// A result reaches rsp_ via the command queue, stages 1 and 2 and the result queue.
// Throughput: one sample per cycle while req_full is low, set by the back end's queue.
// Reset: synchronous; clears the error, the integral and both queues, and loads
// gains 500/0/0 and base speed 4000. csr_ready is always high.
// Depends on lfpd_pkg, lfpd_front, lfpd_cmd_queue and lfpd_back.
`timescale 1ns / 1ps
module line_follow_pid_drive_core
   import lfpd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [SENSOR_W-1:0]       req_sensor_bits,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic                      rsp_left_forward,
   output logic [DUTY_W-1:0]         rsp_left_duty,
   output logic                      rsp_right_forward,
   output logic [DUTY_W-1:0]         rsp_right_duty,
   output logic signed [ERROR_W-1:0] rsp_error_halves,
   output logic                      rsp_all_white,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   lfpd_cfg_type         cfg_ff, cfg_in;
   logic                 cmd_push, cmd_pop, cmd_valid;
   lfpd_cmd_type         cmd_new, cmd_head;
   lfpd_rsp_type         rsp;
   lfpd_back_status_type back_status;

   always_comb begin
      csr_ready = 1'b1;
      cfg_in    = cfg_ff;
      if (csr_valid) begin
         case (lfpd_reg_type'(csr_index))
            REG_GAIN_P:     cfg_in.gain_p     = csr_data[GAIN_W-1:0];
            REG_GAIN_I:     cfg_in.gain_i     = csr_data[GAIN_W-1:0];
            REG_GAIN_D:     cfg_in.gain_d     = csr_data[GAIN_W-1:0];
            REG_BASE_SPEED: cfg_in.base_speed = csr_data[SPEED_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p     <= GAIN_W'(500);
         cfg_ff.gain_i     <= '0;
         cfg_ff.gain_d     <= '0;
         cfg_ff.base_speed <= SPEED_W'(4000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lfpd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_sensor_bits (req_sensor_bits),
      .cmdq_full       (req_full),
      .cmd_push        (cmd_push),
      .cmd             (cmd_new)
   );

   lfpd_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_item (cmd_new),
      .full      (req_full),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .head      (cmd_head)
   );

   lfpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp),
      .status    (back_status)
   );

   assign rsp_left_forward  = rsp.left_forward;
   assign rsp_left_duty     = rsp.left_duty;
   assign rsp_right_forward = rsp.right_forward;
   assign rsp_right_duty    = rsp.right_duty;
   assign rsp_error_halves  = rsp.error_halves;
   assign rsp_all_white     = rsp.all_white;

   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      back_status.inflight <= OUTQ_CNT_W'(OUTQ_DEPTH))
      else $error("back end holds more items than the result queue can take");

   a_duty_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (32'(rsp_left_duty) <= 32'(DUTY_LIMIT))
                  && (32'(rsp_right_duty) <= 32'(DUTY_LIMIT)))
      else $error("wheel duty above the limit");

   a_error_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_error_halves >= -4'sd4) && (rsp_error_halves <= 4'sd4))
      else $error("error out of range");

endmodule
